/* design/cct_pkg.sv */
`timescale 1ns / 1ps

package cct_pkg;

  localparam int COLUMNS_DEF = 3;
  localparam int MAX_LEN_DEF = 63;

  localparam logic [4:0] SHIFT_RESET = 5'd3;
  localparam logic [4:0] ALPHA_LEN   = 5'd26;

  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_UP_Z = 8'h5a;
  localparam logic [7:0] CHAR_LO_A = 8'h61;
  localparam logic [7:0] CHAR_LO_Z = 8'h7a;
  localparam logic [7:0] CHAR_PAD  = 8'h41;

  localparam int PC_W = 3;

  localparam logic [PC_W-1:0] S_LOAD  = 3'd0;
  localparam logic [PC_W-1:0] S_INIT  = 3'd1;
  localparam logic [PC_W-1:0] S_READ  = 3'd2;
  localparam logic [PC_W-1:0] S_EMIT  = 3'd3;
  localparam logic [PC_W-1:0] S_CLEAR = 3'd4;

  localparam logic [2:0] J_NEXT       = 3'd0;
  localparam logic [2:0] J_GOTO       = 3'd1;
  localparam logic [2:0] J_WAIT_LAST  = 3'd2;
  localparam logic [2:0] J_SKIP_EMPTY = 3'd3;
  localparam logic [2:0] J_LOOP       = 3'd4;

  typedef struct packed {
    logic            in_rdy;
    logic            init;
    logic            rd;
    logic            emit;
    logic            clr;
    logic [2:0]      jump;
    logic [PC_W-1:0] target;
  } cct_uop_t;

  typedef struct packed {
    logic last_fire;
    logic empty;
    logic out_busy;
    logic done;
  } cct_stat_t;

  function automatic cct_uop_t ucode(input logic [PC_W-1:0] step);
    cct_uop_t u;
    u = '0;
    case (step)
      S_LOAD: begin
        u.in_rdy = 1'b1;
        u.jump   = J_WAIT_LAST;
      end
      S_INIT: begin
        u.init   = 1'b1;
        u.jump   = J_SKIP_EMPTY;
        u.target = S_CLEAR;
      end
      S_READ: begin
        u.rd   = 1'b1;
        u.jump = J_NEXT;
      end
      S_EMIT: begin
        u.emit   = 1'b1;
        u.jump   = J_LOOP;
        u.target = S_READ;
      end
      S_CLEAR: begin
        u.clr    = 1'b1;
        u.jump   = J_GOTO;
        u.target = S_LOAD;
      end
      default: begin
        u.jump   = J_GOTO;
        u.target = S_LOAD;
      end
    endcase
    return u;
  endfunction

endpackage

/* design/cct_if.sv */
`timescale 1ns / 1ps

interface cct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_in;
  modport source(output valid, char_in, last_in, input ready);
  modport sink(input valid, char_in, last_in, output ready);
endinterface

interface cct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       column_end;
  logic       last_out;
  logic       overflow;
  modport source(output valid, char_out, column_end, last_out, overflow, input ready);
  modport sink(input valid, char_out, column_end, last_out, overflow, output ready);
endinterface

interface cct_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] shift_amount;
  modport source(output valid, shift_amount, input ready);
  modport sink(input valid, shift_amount, output ready);
endinterface

/* design/cct_seq.sv */
`timescale 1ns / 1ps

module cct_seq import cct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cct_stat_t stat,
  output cct_uop_t  uop
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;

  assign uop = ucode(pc);

  always_comb begin
    case (uop.jump)
      J_NEXT:       pc_next = pc + 1'b1;
      J_GOTO:       pc_next = uop.target;
      J_WAIT_LAST:  pc_next = stat.last_fire ? pc + 1'b1 : pc;
      J_SKIP_EMPTY: pc_next = stat.empty ? uop.target : pc + 1'b1;
      J_LOOP: begin
        if (stat.out_busy) begin
          pc_next = pc;
        end else if (stat.done) begin
          pc_next = pc + 1'b1;
        end else begin
          pc_next = uop.target;
        end
      end
      default:      pc_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  a_last_starts_drain: assert property (@(posedge clk) disable iff (rst)
    stat.last_fire |=> pc == S_INIT)
    else $error("last request did not start the drain");

endmodule

/* design/cct_datapath.sv */
`timescale 1ns / 1ps

module cct_datapath import cct_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cct_uop_t  uop,
  output cct_stat_t stat,
  cct_in_if.sink    src,
  cct_out_if.source dst,
  cct_cfg_if.sink   cfg
);

  localparam int CAPACITY = (MAX_LEN / COLUMNS) * COLUMNS;
  localparam int CNT_W    = $clog2(MAX_LEN + 1);
  localparam int ADDR_W   = $clog2(MAX_LEN);
  localparam int COL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] STRIDE   = CNT_W'(COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

  logic [4:0]       shift;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] rows;
  logic [COL_W-1:0] load_col;
  logic             dropped;
  logic [COL_W-1:0] col;
  logic [CNT_W-1:0] row;
  logic [CNT_W-1:0] pos;
  logic [7:0]       mem [0:MAX_LEN-1];
  logic [7:0]       rd_data;
  logic             out_valid;
  logic [7:0]       out_char;
  logic             out_col_end;
  logic             out_last;
  logic             out_ovf;

  logic [4:0] shift_mod;
  logic       is_up;
  logic       is_lo;
  logic [7:0] base;
  logic [7:0] diff;
  logic [5:0] sum;
  logic [5:0] wrapped;
  logic [7:0] rot;
  logic       in_fire;
  logic       has_room;
  logic       out_busy;
  logic       emit_go;
  logic       col_end;

  // letter rotation
  always_comb begin
    shift_mod = (shift >= ALPHA_LEN) ? shift - ALPHA_LEN : shift;
    is_up     = (src.char_in >= CHAR_UP_A) && (src.char_in <= CHAR_UP_Z);
    is_lo     = (src.char_in >= CHAR_LO_A) && (src.char_in <= CHAR_LO_Z);
    base      = is_up ? CHAR_UP_A : CHAR_LO_A;
    diff      = src.char_in - base;
    sum       = {1'b0, diff[4:0]} + {1'b0, shift_mod};
    wrapped   = (sum >= {1'b0, ALPHA_LEN}) ? sum - {1'b0, ALPHA_LEN} : sum;
    rot       = (is_up || is_lo) ? base + {3'b000, wrapped[4:0]} : src.char_in;
  end

  assign src.ready = uop.in_rdy;
  assign cfg.ready = 1'b1;
  assign in_fire   = src.valid && src.ready;
  assign has_room  = fill < CAP_C;
  assign out_busy  = out_valid && !dst.ready;
  assign emit_go   = uop.emit && !out_busy;
  assign col_end   = (row == rows - 1'b1);

  assign stat.last_fire = in_fire && src.last_in;
  assign stat.empty     = (rows == '0);
  assign stat.out_busy  = out_busy;
  assign stat.done      = col_end && (col == COL_LAST);

  assign dst.valid      = out_valid;
  assign dst.char_out   = out_char;
  assign dst.column_end = out_col_end;
  assign dst.last_out   = out_last;
  assign dst.overflow   = out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift     <= SHIFT_RESET;
      fill      <= '0;
      rows      <= '0;
      load_col  <= '0;
      dropped   <= 1'b0;
      col       <= '0;
      row       <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        shift <= cfg.shift_amount;
      end
      if (in_fire) begin
        if (has_room) begin
          fill     <= fill + 1'b1;
          load_col <= (load_col == COL_LAST) ? '0 : load_col + 1'b1;
          if (load_col == '0) begin
            rows <= rows + 1'b1;
          end
        end else begin
          dropped <= 1'b1;
        end
      end
      if (uop.init) begin
        col <= '0;
        row <= '0;
        pos <= '0;
      end
      if (emit_go) begin
        if (col_end) begin
          row <= '0;
          col <= col + 1'b1;
          pos <= CNT_W'(col) + 1'b1;
        end else begin
          row <= row + 1'b1;
          pos <= pos + STRIDE;
        end
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (dst.ready) begin
        out_valid <= 1'b0;
      end
      if (uop.clr) begin
        fill     <= '0;
        rows     <= '0;
        load_col <= '0;
        dropped  <= 1'b0;
      end
    end
  end

  // grid memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (in_fire && has_room) begin
      mem[fill[ADDR_W-1:0]] <= rot;
    end
    if (uop.rd) begin
      rd_data <= mem[pos[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_char    <= (pos < fill) ? rd_data : CHAR_PAD;
      out_col_end <= col_end;
      out_last    <= col_end && (col == COL_LAST);
      out_ovf     <= dropped;
    end
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    uop.clr |=> (fill == '0) && (rows == '0) && !dropped)
    else $error("clear step left grid state behind");

  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    in_fire && !has_room |=> dropped && (fill == CAP_C))
    else $error("drop without a full grid");

  a_last_ends_column: assert property (@(posedge clk) disable iff (rst)
    dst.valid && dst.last_out |-> dst.column_end)
    else $error("last byte not at a column end");

endmodule

/* design/caesar_columnar_transposer_top.sv */
`timescale 1ns / 1ps

// channel     modport  payload                                      request
// stream_in   sink     char_in[7:0], last_in                        message byte
// stream_out  source   char_out[7:0], column_end, last_out, overflow  grid byte
// cfg         sink     shift_amount[4:0]                            rotation write
//
// loading takes one request per cycle; a request with last_in starts the drain
// the drain reads then emits each output byte, after a setup step and before a
// clear step; stream_in is held off during the drain
// an output stall holds the emit step; cfg is always ready
// synchronous reset, shift_amount resets to 3, no clearing pass on the grid

module caesar_columnar_transposer_top import cct_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  cct_in_if.sink    stream_in,
  cct_out_if.source stream_out,
  cct_cfg_if.sink   cfg
);

  cct_uop_t  uop;
  cct_stat_t stat;

  cct_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .uop  (uop)
  );

  cct_datapath #(
    .COLUMNS (COLUMNS),
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .uop  (uop),
    .stat (stat),
    .src  (stream_in),
    .dst  (stream_out),
    .cfg  (cfg)
  );

endmodule
